// ===== hw/rtl/sgi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg
// shared types and constants of the segment intersection core
// ----------------------------------------------------------------------------
package sgi_pkg;

    // result codes
    typedef enum logic [2:0] {
        ST_INTERSECT  = 3'd0,
        ST_COINCIDENT = 3'd1,
        ST_PARALLEL   = 3'd2,
        ST_OUT_AX     = 3'd3,
        ST_OUT_BX     = 3'd4,
        ST_OUT_AY     = 3'd5,
        ST_OUT_BY     = 3'd6
    } status_t;

    // register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_NUM_TOL  = 2'd0;
    localparam logic [1:0] REG_DEN_TOL  = 2'd1;
    localparam logic [1:0] REG_SPAN_TOL = 2'd2;

    localparam int NUM_TOL_W  = 20;
    localparam int DEN_TOL_W  = 16;
    localparam int SPAN_TOL_W = 8;

    typedef struct packed {
        logic [NUM_TOL_W-1:0]  num_tol;
        logic [DEN_TOL_W-1:0]  den_tol;
        logic [SPAN_TOL_W-1:0] span_tol;
    } tol_t;

endpackage

// ===== hw/rtl/sgi_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_regs
// apb tolerance registers of the segment intersection core
// ----------------------------------------------------------------------------
module sgi_regs #(
    parameter int FRAC_BITS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgi_pkg::PADDR_W-1:0]  paddr,
    input  logic [sgi_pkg::PDATA_W-1:0]  pwdata,
    output logic [sgi_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output sgi_pkg::tol_t                tol
);
    import sgi_pkg::*;

    // defaults are about 0.1 in the matching fixed-point scale
    localparam logic [63:0] NUM_RST  = ((64'd1 << (3 * FRAC_BITS)) + 64'd5) / 64'd10;
    localparam logic [63:0] DEN_RST  = ((64'd1 << (2 * FRAC_BITS)) + 64'd5) / 64'd10;
    localparam logic [63:0] SPAN_RST = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

    tol_t tol_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign tol    = tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg.num_tol  <= NUM_TOL_W'(NUM_RST);
            tol_reg.den_tol  <= DEN_TOL_W'(DEN_RST);
            tol_reg.span_tol <= SPAN_TOL_W'(SPAN_RST);
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_NUM_TOL:  tol_reg.num_tol  <= pwdata[NUM_TOL_W-1:0];
                REG_DEN_TOL:  tol_reg.den_tol  <= pwdata[DEN_TOL_W-1:0];
                REG_SPAN_TOL: tol_reg.span_tol <= pwdata[SPAN_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM_TOL:  prdata = PDATA_W'(tol_reg.num_tol);
            REG_DEN_TOL:  prdata = PDATA_W'(tol_reg.den_tol);
            REG_SPAN_TOL: prdata = PDATA_W'(tol_reg.span_tol);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/sgi_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_divider
// pipelined restoring divider, one quotient bit per stage, with side payload
// ----------------------------------------------------------------------------
module sgi_divider #(
    parameter int  NW = 52,
    parameter int  DW = 35,
    parameter int  QW = 25,
    parameter type CTX_T = logic
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  CTX_T          in_ctx,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic          overflow,
    output CTX_T          out_ctx
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]   vld_reg;
    logic [QW:0]   ovf_reg;
    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [DW-1:0] dvs_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    CTX_T          ctx_reg [QW+1];

    logic [DW-1:0] rem_next [1:QW];
    logic [QW-1:0] quo_next [1:QW];
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // one trial subtraction per stage
    always_comb begin
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        for (int k = 1; k <= QW; k++) begin
            trial       = {rem_reg[k-1], low_reg[k-1][QW-k]};
            ge          = trial >= {1'b0, dvs_reg[k-1]};
            diff        = trial - {1'b0, dvs_reg[k-1]};
            rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next[k] = quo_reg[k-1] | (QW'(ge) << (QW - k));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient fits QW bits only when the top part is below the divisor
            rem_reg[0] <= DW'(dividend[NW-1:QW]);
            low_reg[0] <= dividend[QW-1:0];
            dvs_reg[0] <= divisor;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CW'(dividend[NW-1:QW]) >= CW'(divisor);
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k <= QW; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_reg[k-1];
                dvs_reg[k] <= dvs_reg[k-1];
                quo_reg[k] <= quo_next[k];
                ovf_reg[k] <= ovf_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quotient  = quo_reg[QW];
    assign overflow  = ovf_reg[QW];
    assign out_ctx   = ctx_reg[QW];

endmodule

// ===== hw/rtl/segment_intersection_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_core
// fixed-point intersection of two 2d segments, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item = segments a and b, four signed qm.f coordinates each
//   m_ channel: one item = status code plus intersection point (saturated,
//     zero for coincident or parallel pairs)
//   apb port: numerator, denominator and span tolerances at 0x0, 0x4, 0x8;
//     write only while the core is empty
//   throughput: one item per cycle while no stalled output item holds the
//     pipeline; each item passes the cross-product stages, the two
//     bit-serial divider pipelines (COORD_WIDTH+9 quotient bits each) and
//     the span-check stages
//   stall: the whole pipeline advances on one enable; when m_valid is held
//     by a low m_ready every stage freezes and s_ready drops, so nothing is
//     dropped or repeated
//   reset: aresetn (sync, low) clears all valid bits and reloads the
//     tolerance registers with their defaults
// ----------------------------------------------------------------------------
module segment_intersection_2d_core #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_WIDTH-1:0]     s_a_start_x,
    input  logic signed [COORD_WIDTH-1:0]     s_a_start_y,
    input  logic signed [COORD_WIDTH-1:0]     s_a_end_x,
    input  logic signed [COORD_WIDTH-1:0]     s_a_end_y,
    input  logic signed [COORD_WIDTH-1:0]     s_b_start_x,
    input  logic signed [COORD_WIDTH-1:0]     s_b_start_y,
    input  logic signed [COORD_WIDTH-1:0]     s_b_end_x,
    input  logic signed [COORD_WIDTH-1:0]     s_b_end_y,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output sgi_pkg::status_t                  m_status,
    output logic signed [COORD_WIDTH-1:0]     m_point_x,
    output logic signed [COORD_WIDTH-1:0]     m_point_y,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sgi_pkg::PADDR_W-1:0]       paddr,
    input  logic [sgi_pkg::PDATA_W-1:0]       pwdata,
    output logic [sgi_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import sgi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int NUMW = 3 * W + 4;     // numerator
    localparam int DENW = 2 * W + 3;     // denominator
    localparam int QW   = W + 9;         // quotient bits of both dividers
    localparam int PXW  = W + 10;        // clamped x and x offset
    localparam int PRW  = 2 * W + 11;    // slope product
    localparam int PYW  = W + 11;        // derived y
    localparam int EW   = W + 12;        // span compare width

    localparam logic [PXW-1:0] LIM_MAG = PXW'(1) << (W + 8);
    localparam logic signed [EW-1:0] CMAX = EW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);

    typedef struct packed {
        logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    } seg_t;

    typedef struct packed {
        logic signed [W:0] dxa, dya, dxb, dyb;
    } delta_t;

    typedef struct packed {
        logic coin;   // identical segments
        logic e1;     // b collapsed onto a's first endpoint
        logic e2;     // b collapsed onto a's second endpoint
    } flag_t;

    typedef struct packed {
        seg_t   s;
        delta_t d;
        flag_t  f;
    } front_t;

    typedef struct packed {
        seg_t                s;
        logic signed [W-1:0] bx, by;   // base point of the line used for y
        logic signed [W:0]   dx, dy;
        logic                done;     // result known without division
        status_t             st;
        logic signed [W-1:0] ex, ey;
        logic                qneg;
    } ctx_t;

    typedef struct packed {
        ctx_t                  c;
        logic signed [PXW-1:0] px;
        logic                  yneg;
    } ctx2_t;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    tol_t tol;

    sgi_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    // single pipeline enable: advance unless the output item is stalled
    logic m_valid_reg;
    logic en;
    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 1: deltas and endpoint compares
    // ------------------------------------------------------------------
    front_t fr_c;

    always_comb begin
        fr_c.s.x1 = s_a_start_x;
        fr_c.s.y1 = s_a_start_y;
        fr_c.s.x2 = s_a_end_x;
        fr_c.s.y2 = s_a_end_y;
        fr_c.s.x3 = s_b_start_x;
        fr_c.s.y3 = s_b_start_y;
        fr_c.s.x4 = s_b_end_x;
        fr_c.s.y4 = s_b_end_y;
        fr_c.d.dxa = (W+1)'(s_a_end_x) - (W+1)'(s_a_start_x);
        fr_c.d.dya = (W+1)'(s_a_end_y) - (W+1)'(s_a_start_y);
        fr_c.d.dxb = (W+1)'(s_b_end_x) - (W+1)'(s_b_start_x);
        fr_c.d.dyb = (W+1)'(s_b_end_y) - (W+1)'(s_b_start_y);
        fr_c.f.coin = (s_a_start_x == s_b_start_x) && (s_a_start_y == s_b_start_y) &&
                      (s_a_end_x == s_b_end_x) && (s_a_end_y == s_b_end_y);
        fr_c.f.e1   = (s_a_start_x == s_b_start_x) && (s_a_start_y == s_b_start_y) &&
                      (s_a_start_x == s_b_end_x) && (s_a_start_y == s_b_end_y);
        fr_c.f.e2   = (s_a_end_x == s_b_start_x) && (s_a_end_y == s_b_start_y) &&
                      (s_a_end_x == s_b_end_x) && (s_a_end_y == s_b_end_y);
    end

    // ------------------------------------------------------------------
    // front pipeline registers
    // ------------------------------------------------------------------
    logic [5:0] fv_reg;
    front_t     fr1_reg, fr2_reg, fr3_reg, fr4_reg, fr5_reg;

    logic signed [2*W:0]   pa2_reg, pb2_reg, pc2_reg, pd2_reg;   // coordinate * delta
    logic signed [2*W+1:0] pe2_reg, pf2_reg;                     // delta * delta
    logic signed [2*W+1:0] c13_reg, c23_reg;
    logic signed [DENW-1:0] den3_reg;
    logic signed [3*W+2:0] m14_reg, m24_reg;
    logic                  dsm4_reg, dsm5_reg;
    logic [DENW-1:0]       dmag4_reg, dmag5_reg, dmag6_reg;
    logic                  dneg4_reg, dneg5_reg;
    logic signed [NUMW-1:0] num5_reg;
    logic [NUMW-1:0]       nmag6_reg;
    ctx_t                  ctx6_reg;

    // stage 4 denominator tests
    logic signed [DENW-1:0] dtol_s;
    logic                   dsm_c;
    logic [DENW-1:0]        dmag_c;

    assign dtol_s = DENW'(tol.den_tol);
    assign dsm_c  = (den3_reg == '0) || ((den3_reg < dtol_s) && (den3_reg > -dtol_s));
    assign dmag_c = den3_reg[DENW-1] ? -den3_reg : den3_reg;

    // stage 6 numerator test and early decisions
    logic signed [NUMW-1:0] ntol_s;
    logic                   nsm_c;
    logic                   sel_a;
    ctx_t                   ctx_c;

    assign ntol_s = NUMW'(tol.num_tol);
    assign nsm_c  = (num5_reg == '0) || ((num5_reg < ntol_s) && (num5_reg > -ntol_s));
    assign sel_a  = (fr5_reg.d.dxa != '0);

    always_comb begin
        ctx_c.s    = fr5_reg.s;
        // y follows a's line unless a is vertical
        ctx_c.bx   = sel_a ? fr5_reg.s.x1 : fr5_reg.s.x3;
        ctx_c.by   = sel_a ? fr5_reg.s.y1 : fr5_reg.s.y3;
        ctx_c.dx   = sel_a ? fr5_reg.d.dxa : fr5_reg.d.dxb;
        ctx_c.dy   = sel_a ? fr5_reg.d.dya : fr5_reg.d.dyb;
        ctx_c.qneg = num5_reg[NUMW-1] ^ dneg5_reg;
        ctx_c.done = 1'b0;
        ctx_c.st   = ST_INTERSECT;
        ctx_c.ex   = '0;
        ctx_c.ey   = '0;
        if (fr5_reg.f.coin) begin
            ctx_c.done = 1'b1;
            ctx_c.st   = ST_COINCIDENT;
        end else if (fr5_reg.f.e1) begin
            ctx_c.done = 1'b1;
            ctx_c.ex   = fr5_reg.s.x1;
            ctx_c.ey   = fr5_reg.s.y1;
        end else if (fr5_reg.f.e2) begin
            ctx_c.done = 1'b1;
            ctx_c.ex   = fr5_reg.s.x2;
            ctx_c.ey   = fr5_reg.s.y2;
        end else if (dsm5_reg) begin
            ctx_c.done = 1'b1;
            ctx_c.st   = nsm_c ? ST_COINCIDENT : ST_PARALLEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[4:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            fr1_reg  <= fr_c;
            // stage 2: cross products
            fr2_reg  <= fr1_reg;
            pa2_reg  <= fr1_reg.s.y3 * fr1_reg.d.dxb;
            pb2_reg  <= fr1_reg.s.x3 * fr1_reg.d.dyb;
            pc2_reg  <= fr1_reg.s.y1 * fr1_reg.d.dxa;
            pd2_reg  <= fr1_reg.s.x1 * fr1_reg.d.dya;
            pe2_reg  <= fr1_reg.d.dya * fr1_reg.d.dxb;
            pf2_reg  <= fr1_reg.d.dyb * fr1_reg.d.dxa;
            // stage 3: line constants and denominator
            fr3_reg  <= fr2_reg;
            c13_reg  <= (2*W+2)'(pa2_reg) - (2*W+2)'(pb2_reg);
            c23_reg  <= (2*W+2)'(pc2_reg) - (2*W+2)'(pd2_reg);
            den3_reg <= DENW'(pe2_reg) - DENW'(pf2_reg);
            // stage 4: numerator products, denominator tests
            fr4_reg   <= fr3_reg;
            m14_reg   <= fr3_reg.d.dxa * c13_reg;
            m24_reg   <= fr3_reg.d.dxb * c23_reg;
            dsm4_reg  <= dsm_c;
            dmag4_reg <= dmag_c;
            dneg4_reg <= den3_reg[DENW-1];
            // stage 5: numerator
            fr5_reg   <= fr4_reg;
            num5_reg  <= NUMW'(m14_reg) - NUMW'(m24_reg);
            dsm5_reg  <= dsm4_reg;
            dmag5_reg <= dmag4_reg;
            dneg5_reg <= dneg4_reg;
            // stage 6: magnitudes for the divider
            ctx6_reg  <= ctx_c;
            nmag6_reg <= num5_reg[NUMW-1] ? -num5_reg : num5_reg;
            dmag6_reg <= dmag5_reg;
        end
    end

    // ------------------------------------------------------------------
    // x = num / den
    // ------------------------------------------------------------------
    logic           d1_valid;
    logic [QW-1:0]  d1_quo;
    logic           d1_ovf;
    ctx_t           d1_ctx;

    sgi_divider #(
        .NW    (NUMW),
        .DW    (DENW),
        .QW    (QW),
        .CTX_T (ctx_t)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv_reg[5]),
        .dividend  (nmag6_reg),
        .divisor   (dmag6_reg),
        .in_ctx    (ctx6_reg),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .overflow  (d1_ovf),
        .out_ctx   (d1_ctx)
    );

    // ------------------------------------------------------------------
    // middle stages: clamp x, offset, slope product, magnitudes
    // ------------------------------------------------------------------
    logic [3:0]             mv_reg;
    ctx_t                   ctx7_reg;
    logic signed [PXW-1:0]  px7_reg;
    ctx2_t                  cx8_reg, cx9_reg, cx10_reg;
    logic signed [PXW-1:0]  diff8_reg;
    logic signed [PRW-1:0]  prod9_reg;
    logic [PRW-1:0]         pmag10_reg;
    logic [W:0]             dxmag10_reg;

    logic [PXW-1:0] xmag_c;
    ctx2_t          cx10_c;

    // far intersections clamp to +-2^(W+8)
    assign xmag_c = (d1_ovf || (PXW'(d1_quo) > LIM_MAG)) ? LIM_MAG : PXW'(d1_quo);

    always_comb begin
        cx10_c      = cx9_reg;
        cx10_c.yneg = prod9_reg[PRW-1] ^ cx9_reg.c.dx[W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= '0;
        end else if (en) begin
            mv_reg <= {mv_reg[2:0], d1_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx7_reg     <= d1_ctx;
            px7_reg      <= d1_ctx.qneg ? -xmag_c : xmag_c;
            cx8_reg.c    <= ctx7_reg;
            cx8_reg.px   <= px7_reg;
            cx8_reg.yneg <= 1'b0;
            diff8_reg    <= px7_reg - PXW'(ctx7_reg.bx);
            cx9_reg      <= cx8_reg;
            prod9_reg    <= cx8_reg.c.dy * diff8_reg;
            cx10_reg     <= cx10_c;
            pmag10_reg   <= prod9_reg[PRW-1] ? -prod9_reg : prod9_reg;
            dxmag10_reg  <= cx9_reg.c.dx[W] ? -cx9_reg.c.dx : cx9_reg.c.dx;
        end
    end

    // ------------------------------------------------------------------
    // y offset = dy * (x - bx) / dx
    // ------------------------------------------------------------------
    logic           d2_valid;
    logic [QW-1:0]  d2_quo;
    logic           d2_ovf;
    ctx2_t          d2_ctx;

    sgi_divider #(
        .NW    (PRW),
        .DW    (W + 1),
        .QW    (QW),
        .CTX_T (ctx2_t)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mv_reg[3]),
        .dividend  (pmag10_reg),
        .divisor   (dxmag10_reg),
        .in_ctx    (cx10_reg),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .overflow  (d2_ovf),
        .out_ctx   (d2_ctx)
    );

    // ------------------------------------------------------------------
    // back end: y, span checks, saturation, output register
    // ------------------------------------------------------------------
    function automatic logic outside_f(
        input logic signed [EW-1:0] v,
        input logic signed [EW-1:0] p,
        input logic signed [EW-1:0] q,
        input logic [SPAN_TOL_W-1:0] t
    );
        logic signed [EW-1:0] mx;
        logic signed [EW-1:0] mn;
        logic signed [EW-1:0] ts;
        ts = EW'(t);
        mx = (p > q) ? p : q;
        mn = (p > q) ? q : p;
        return (v > mx + ts) || (v < mn - ts);
    endfunction

    function automatic logic signed [W-1:0] sat_f(input logic signed [EW-1:0] v);
        if (v > CMAX) begin
            return W'(CMAX);
        end else if (v < CMIN) begin
            return W'(CMIN);
        end
        return W'(v);
    endfunction

    logic                  v11_reg;
    ctx2_t                 cx11_reg;
    logic signed [PYW-1:0] py11_reg;
    logic [QW-1:0]         ymag_c;
    logic signed [PYW-1:0] yoff_c;

    // a huge offset only needs to stay far out of range
    assign ymag_c = d2_ovf ? '1 : d2_quo;
    assign yoff_c = d2_ctx.yneg ? -(PYW'(ymag_c)) : PYW'(ymag_c);

    status_t              m_status_reg;
    logic signed [W-1:0]  m_point_x_reg;
    logic signed [W-1:0]  m_point_y_reg;

    status_t              st_next;
    logic signed [W-1:0]  x_next;
    logic signed [W-1:0]  y_next;
    logic signed [EW-1:0] xe;
    logic signed [EW-1:0] ye;

    always_comb begin
        xe = EW'(cx11_reg.px);
        ye = EW'(py11_reg);
        if (cx11_reg.c.done) begin
            st_next = cx11_reg.c.st;
            x_next  = cx11_reg.c.ex;
            y_next  = cx11_reg.c.ey;
        end else begin
            x_next = sat_f(xe);
            y_next = sat_f(ye);
            if (outside_f(xe, EW'(cx11_reg.c.s.x1), EW'(cx11_reg.c.s.x2), tol.span_tol)) begin
                st_next = ST_OUT_AX;
            end else if (outside_f(xe, EW'(cx11_reg.c.s.x3), EW'(cx11_reg.c.s.x4),
                                   tol.span_tol)) begin
                st_next = ST_OUT_BX;
            end else if (outside_f(ye, EW'(cx11_reg.c.s.y1), EW'(cx11_reg.c.s.y2),
                                   tol.span_tol)) begin
                st_next = ST_OUT_AY;
            end else if (outside_f(ye, EW'(cx11_reg.c.s.y3), EW'(cx11_reg.c.s.y4),
                                   tol.span_tol)) begin
                st_next = ST_OUT_BY;
            end else begin
                st_next = ST_INTERSECT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v11_reg     <= d2_valid;
            m_valid_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx11_reg      <= d2_ctx;
            py11_reg      <= PYW'(d2_ctx.c.by) + yoff_c;
            m_status_reg  <= st_next;
            m_point_x_reg <= x_next;
            m_point_y_reg <= y_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;

endmodule

// ===== hw/rtl/sgi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_checker
// port-level checks of the segment intersection core
// ----------------------------------------------------------------------------
module sgi_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input sgi_pkg::status_t              m_status,
    input logic signed [COORD_WIDTH-1:0] m_point_x,
    input logic signed [COORD_WIDTH-1:0] m_point_y
);
    import sgi_pkg::*;

    // no result item right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item right after reset");

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
                                $stable(m_point_x) && $stable(m_point_y))
        else $error("stalled result item changed");

    // input side only blocks behind a stalled output
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready while output empty");

    // status code in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_OUT_BY)
        else $error("status code out of range");

    // no point for coincident or parallel pairs
    a_no_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_COINCIDENT || m_status == ST_PARALLEL) |->
            m_point_x == '0 && m_point_y == '0)
        else $error("point reported without intersection");

endmodule

bind segment_intersection_2d_core sgi_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sgi_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y)
);

// ===== test/tb_segment_intersection_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_2d_core
// self-checking bench: random and directed segment pairs go in through the
// s_ channel, every m_ item is checked against a built-in predictor, and the
// tolerance registers are rewritten between phases over apb
// ----------------------------------------------------------------------------
module tb_segment_intersection_2d_core;
    import sgi_pkg::*;

    typedef logic signed [15:0] coord_t;

    // one input item: segment a then segment b
    typedef struct {
        coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
    } pair_t;

    // one result item
    typedef struct {
        status_t st;
        coord_t  px, py;
    } hit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_a_start_x = '0, s_a_start_y = '0, s_a_end_x = '0, s_a_end_y = '0;
    coord_t s_b_start_x = '0, s_b_start_y = '0, s_b_end_x = '0, s_b_end_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    coord_t m_point_x, m_point_y;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    segment_intersection_2d_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_start_x(s_a_start_x), .s_a_start_y(s_a_start_y),
        .s_a_end_x(s_a_end_x), .s_a_end_y(s_a_end_y),
        .s_b_start_x(s_b_start_x), .s_b_start_y(s_b_start_y),
        .s_b_end_x(s_b_end_x), .s_b_end_y(s_b_end_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_point_x(m_point_x), .m_point_y(m_point_y),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // bench copy of the tolerance registers, reset values first
    logic [NUM_TOL_W-1:0]  num_tol  = 20'd410;
    logic [DEN_TOL_W-1:0]  den_tol  = 16'd26;
    logic [SPAN_TOL_W-1:0] span_tol = 8'd2;

    pair_t pending_pairs[$];
    hit_t  expected_hits[$];
    int    err_count = 0;
    logic  idle_en = 1'b1;
    logic  s_fire = 1'b0;
    int    tx_gap = 0;
    int    rx_hold = 0;
    int    press_req = 0, press_seen = 0;

    // append to the tail of the pending and expected queues
    function automatic void add_pair(pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic void add_hit(hit_t h);
        expected_hits.insert(expected_hits.size(), h);
    endfunction

    function automatic coord_t sat_coord(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return coord_t'(v);
    endfunction

    function automatic bit near_zero(longint v, longint tol);
        return v == 0 || (v < 0 ? -v : v) < tol;
    endfunction

    // true when v lies beyond the span [p, q] by more than the slack
    function automatic bit off_span(longint v, longint p, longint q, longint tol);
        longint hi, lo;
        hi = p > q ? p : q;
        lo = p > q ? q : p;
        return (v - hi > tol) || (v - lo < -tol);
    endfunction

    function automatic hit_t predict_hit(pair_t s);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dxa, dya, dxb, dyb, num, den, px, py, lim, st;
        hit_t h;
        x1 = longint'(s.asx); y1 = longint'(s.asy);
        x2 = longint'(s.aex); y2 = longint'(s.aey);
        x3 = longint'(s.bsx); y3 = longint'(s.bsy);
        x4 = longint'(s.bex); y4 = longint'(s.bey);
        dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
        h.px = '0;
        h.py = '0;
        // identical segments
        if (x1 == x3 && y1 == y3 && x2 == x4 && y2 == y4) begin
            h.st = ST_COINCIDENT;
            return h;
        end
        // b collapsed onto one endpoint of a
        if (x1 == x3 && y1 == y3 && x1 == x4 && y1 == y4) begin
            h.st = ST_INTERSECT; h.px = s.asx; h.py = s.asy;
            return h;
        end
        if (x2 == x3 && y2 == y3 && x2 == x4 && y2 == y4) begin
            h.st = ST_INTERSECT; h.px = s.aex; h.py = s.aey;
            return h;
        end
        num = dxa * (y3 * dxb - x3 * dyb) - dxb * (y1 * dxa - x1 * dya);
        den = dya * dxb - dyb * dxa;
        if (near_zero(den, longint'(den_tol))) begin
            h.st = near_zero(num, longint'(num_tol)) ? ST_COINCIDENT : ST_PARALLEL;
            return h;
        end
        lim = 64'sd1 << 24;
        px = num / den;
        if (px > lim) px = lim;
        if (px < -lim) px = -lim;
        // y from a's line unless a is vertical
        if (dxa != 0) py = y1 + (dya * (px - x1)) / dxa;
        else          py = y3 + (dyb * (px - x3)) / dxb;
        st = longint'(span_tol);
        if (off_span(px, x1, x2, st))      h.st = ST_OUT_AX;
        else if (off_span(px, x3, x4, st)) h.st = ST_OUT_BX;
        else if (off_span(py, y1, y2, st)) h.st = ST_OUT_AY;
        else if (off_span(py, y3, y4, st)) h.st = ST_OUT_BY;
        else                               h.st = ST_INTERSECT;
        h.px = sat_coord(px);
        h.py = sat_coord(py);
        return h;
    endfunction

    task automatic report_err(string what);
        err_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // sender: a new item only once the last one was taken
    always @(negedge aclk) begin
        pair_t p;
        if (aresetn && (!s_valid || s_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                if (idle_en && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else begin
                    p = pending_pairs.pop_front();
                    s_valid <= 1'b1;
                    s_a_start_x <= p.asx; s_a_start_y <= p.asy;
                    s_a_end_x <= p.aex;   s_a_end_y <= p.aey;
                    s_b_start_x <= p.bsx; s_b_start_y <= p.bsy;
                    s_b_end_x <= p.bex;   s_b_end_y <= p.bey;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (press_req != press_seen) begin
            press_seen = press_req;
            rx_hold = 299;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on input handshake, compare on output handshake
    always @(posedge aclk) begin
        pair_t p;
        hit_t h;
        s_fire <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            p.asx = s_a_start_x; p.asy = s_a_start_y;
            p.aex = s_a_end_x;   p.aey = s_a_end_y;
            p.bsx = s_b_start_x; p.bsy = s_b_start_y;
            p.bex = s_b_end_x;   p.bey = s_b_end_y;
            add_hit(predict_hit(p));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                report_err("result item with nothing expected");
            end else begin
                h = expected_hits.pop_front();
                if (m_status !== h.st)
                    report_err($sformatf("status %0d, want %0d", m_status, h.st));
                if (m_point_x !== h.px)
                    report_err($sformatf("point_x %0d, want %0d", m_point_x, h.px));
                if (m_point_y !== h.py)
                    report_err($sformatf("point_y %0d, want %0d", m_point_y, h.py));
            end
        end
    end

    // apb write: setup then access, bench copy follows
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_NUM_TOL:  num_tol  = val[NUM_TOL_W-1:0];
            REG_DEN_TOL:  den_tol  = val[DEN_TOL_W-1:0];
            REG_SPAN_TOL: span_tol = val[SPAN_TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_tols(logic [31:0] n, logic [31:0] d, logic [31:0] sp);
        reg_write(REG_NUM_TOL, n);
        reg_write(REG_DEN_TOL, d);
        reg_write(REG_SPAN_TOL, sp);
    endtask

    // wait for every item to come back, then idle for longer than the pipeline depth
    task automatic drain();
        do @(posedge aclk);
        while (pending_pairs.size() > 0 || s_valid || expected_hits.size() > 0);
        repeat (80) @(negedge aclk);
    endtask

    function automatic pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        pair_t p;
        p.asx = coord_t'(a); p.asy = coord_t'(b); p.aex = coord_t'(c); p.aey = coord_t'(d);
        p.bsx = coord_t'(e); p.bsy = coord_t'(f); p.bex = coord_t'(g); p.bey = coord_t'(h);
        return p;
    endfunction

    function automatic coord_t rnd_coord(int span);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // random pair, shaped toward one kind of geometry
    function automatic pair_t rand_pair();
        pair_t p;
        int k, dx, dy, m;
        k = $urandom_range(0, 9);
        p.asx = rnd_coord(2000); p.asy = rnd_coord(2000);
        p.aex = rnd_coord(2000); p.aey = rnd_coord(2000);
        p.bsx = rnd_coord(2000); p.bsy = rnd_coord(2000);
        p.bex = rnd_coord(2000); p.bey = rnd_coord(2000);
        case (k)
            0, 1: begin // full range noise
                p.asx = coord_t'($urandom); p.asy = coord_t'($urandom);
                p.aex = coord_t'($urandom); p.aey = coord_t'($urandom);
                p.bsx = coord_t'($urandom); p.bsy = coord_t'($urandom);
                p.bex = coord_t'($urandom); p.bey = coord_t'($urandom);
            end
            2: begin // b parallel to a, offset
                dx = int'(p.aex) - int'(p.asx); dy = int'(p.aey) - int'(p.asy);
                m = $urandom_range(0, 3);
                p.bex = coord_t'(int'(p.bsx) + (m == 0 ? dx : -dx));
                p.bey = coord_t'(int'(p.bsy) + (m == 0 ? dy : -dy));
            end
            3: begin // collinear, maybe shifted along a
                dx = int'(p.aex) - int'(p.asx); dy = int'(p.aey) - int'(p.asy);
                m = $urandom_range(0, 2);
                p.bsx = coord_t'(int'(p.asx) + m * dx / 2);
                p.bsy = coord_t'(int'(p.asy) + m * dy / 2);
                p.bex = coord_t'(int'(p.bsx) + dx);
                p.bey = coord_t'(int'(p.bsy) + dy);
            end
            4: begin // vertical a
                p.aex = p.asx;
            end
            5: begin // b collapsed onto an endpoint of a, or identical pair
                m = $urandom_range(0, 2);
                if (m == 0) begin p.bsx = p.asx; p.bsy = p.asy; end
                else begin p.bsx = p.aex; p.bsy = p.aey; end
                p.bex = p.bsx; p.bey = p.bsy;
                if (m == 2) begin
                    p.bsx = p.asx; p.bsy = p.asy; p.bex = p.aex; p.bey = p.aey;
                end
            end
            6: begin // tiny segments near the tolerance edges
                p.aex = p.asx + rnd_coord(6); p.aey = p.asy + rnd_coord(6);
                p.bex = p.bsx + rnd_coord(6); p.bey = p.bsy + rnd_coord(6);
            end
            default: ; // ordinary crossing or miss in a moderate box
        endcase
        return p;
    endfunction

    task automatic queue_random(int n);
        repeat (n) add_pair(rand_pair());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes and each special case, reset tolerances
        add_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        add_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        add_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        add_pair(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        add_pair(mk(100, 200, 300, 400, 100, 200, 300, 400));   // identical
        add_pair(mk(100, 200, 300, 400, 100, 200, 100, 200));   // b on a start
        add_pair(mk(100, 200, 300, 400, 300, 400, 300, 400));   // b on a end
        add_pair(mk(0, 0, 160, 160, 0, 32, 160, 192));          // parallel
        add_pair(mk(0, 0, 160, 160, 32, 32, 320, 320));         // collinear
        add_pair(mk(50, -100, 50, 100, -100, 0, 100, 0));       // vertical a
        add_pair(mk(-160, -160, 160, 160, -160, 160, 160, -160));
        add_pair(mk(0, 0, 16, 16, 32, 0, 48, -16));             // misses b x
        add_pair(mk(0, 0, 32767, 1, 0, 16, 32767, 18));         // far point
        add_pair(mk(0, 0, -32768, 1, 0, 16, -32768, 18));
        add_pair(mk(0, 0, 100, 0, 50, 10, 50, 500));            // misses b y
        add_pair(mk(0, 0, 100, 0, 50, -500, 52, -10));
        add_pair(mk(0, 0, 2, 1, 0, 1, 2, 2));                   // tiny den
        add_pair(mk(-1, -1, 1, 1, 1, -1, -1, 1));
        drain();

        // zero tolerances: only exact zeros count as small
        set_tols(0, 0, 0);
        add_pair(mk(0, 0, 160, 160, 0, 32, 160, 192));
        add_pair(mk(0, 0, 2, 1, 0, 1, 2, 2));
        queue_random(100);
        drain();

        // widest tolerances
        set_tols(32'hFFFFF, 32'hFFFF, 32'hFF);
        queue_random(100);
        drain();

        // random mid values; receiver holds off while the sender keeps offering
        set_tols($urandom_range(0, 20'hFFFFF), $urandom_range(0, 16'hFFFF),
                 $urandom_range(0, 255));
        queue_random(120);
        press_req++;
        drain();

        // back to defaults, no idling on either side
        set_tols(410, 26, 2);
        idle_en = 1'b0;
        queue_random(100);
        drain();

        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
